// ----- hw/rtl/afd_pkg.sv -----
// Shared constants, status codes, result type and hex decode for the frame deframer.
package afd_pkg;

    localparam logic [7:0] CH_STX  = 8'h02;
    localparam logic [7:0] CH_ETX  = 8'h03;
    localparam logic [7:0] CH_ETB  = 8'h17;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_UA   = 8'h41;
    localparam logic [7:0] CH_UF   = 8'h46;
    localparam logic [7:0] CH_LA   = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;
    localparam logic [7:0] HEX_TEN = 8'd10;
    localparam logic [7:0] MAX_RECORD = 8'd7;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_RETX      = 4'd1,
        ST_NO_START  = 4'd2,
        ST_BAD_DIGIT = 4'd3,
        ST_OUT_OF_SEQ = 4'd4,
        ST_BAD_END   = 4'd5,
        ST_BAD_HEX   = 4'd6,
        ST_MISMATCH  = 4'd7,
        ST_BAD_CRLF  = 4'd8
    } status_t;

    typedef struct packed {
        logic       is_verdict;
        logic [7:0] text_byte;
        status_t    status;
        logic [2:0] record_number;
        logic       block_final;
        logic [7:0] computed_checksum;
        logic [7:0] given_checksum;
    } result_t;

    // Bit 4 set: not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        begin
            v = 8'h10;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                v = c - CH_ZERO;
            end
            else if (c >= CH_UA && c <= CH_UF) begin
                v = c - CH_UA + HEX_TEN;
            end
            else if (c >= CH_LA && c <= CH_LF_HEX) begin
                v = c - CH_LA + HEX_TEN;
            end
            return v[4:0];
        end
    endfunction

endpackage

// ----- hw/rtl/afd_parser.sv -----
// Frame parse state machine: per-item next state and result.
module afd_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic               mode,
    input  logic [7:0]         data_byte,
    input  logic               buffer_last,
    output logic               produce,
    output afd_pkg::result_t   res
);

    typedef enum logic [3:0] {
        PH_HUNT  = 4'd0,
        PH_RECNO = 4'd1,
        PH_TEXT  = 4'd2,
        PH_END   = 4'd3,
        PH_HEX1  = 4'd4,
        PH_HEX2  = 4'd5,
        PH_CR    = 4'd6,
        PH_LF    = 4'd7,
        PH_DONE  = 4'd8
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [3:0] exp_reg, exp_next;
    logic [7:0] sum_reg, sum_next;
    logic [3:0] hi_reg, hi_next;
    logic [2:0] rec_reg, rec_next;
    logic       fin_reg, fin_next;

    logic              verdict;
    logic              text;
    afd_pkg::status_t  v_status;
    logic [2:0]        v_rec;
    logic [7:0]        v_given;
    logic [7:0]        digit;
    logic [4:0]        hv;

    always_comb
    begin
        phase_next = phase_reg;
        exp_next   = exp_reg;
        sum_next   = sum_reg;
        hi_next    = hi_reg;
        rec_next   = rec_reg;
        fin_next   = fin_reg;
        verdict    = 1'b0;
        text       = 1'b0;
        v_status   = afd_pkg::ST_OK;
        v_rec      = 3'd0;
        v_given    = 8'd0;
        digit      = data_byte - afd_pkg::CH_ZERO;
        hv         = afd_pkg::hex_value(data_byte);

        if (mode) begin
            phase_next = PH_HUNT;
            exp_next   = 4'd8;
            sum_next   = 8'd0;
            hi_next    = 4'd0;
            rec_next   = 3'd0;
            fin_next   = 1'b0;
        end
        else begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (data_byte == afd_pkg::CH_STX) begin
                        phase_next = PH_RECNO;
                        sum_next   = 8'd0;
                        hi_next    = 4'd0;
                        rec_next   = 3'd0;
                        fin_next   = 1'b0;
                    end
                end
                PH_RECNO:
                begin
                    sum_next = data_byte;
                    if (digit > afd_pkg::MAX_RECORD) begin
                        verdict  = 1'b1;
                        v_status = afd_pkg::ST_BAD_DIGIT;
                    end
                    else begin
                        rec_next = digit[2:0];
                        if (exp_reg[3]) begin
                            exp_next   = {1'b0, digit[2:0]};
                            phase_next = PH_TEXT;
                        end
                        else if (digit[2:0] != exp_reg[2:0]) begin
                            verdict  = 1'b1;
                            v_rec    = digit[2:0];
                            v_status = ((digit[2:0] + 3'd1) == exp_reg[2:0])
                                       ? afd_pkg::ST_RETX : afd_pkg::ST_OUT_OF_SEQ;
                        end
                        else begin
                            phase_next = PH_TEXT;
                        end
                    end
                end
                PH_TEXT:
                begin
                    sum_next = sum_reg + data_byte;
                    if (data_byte == afd_pkg::CH_CR) begin
                        phase_next = PH_END;
                    end
                    else if (!buffer_last) begin
                        text = 1'b1;
                    end
                end
                PH_END:
                begin
                    if (data_byte != afd_pkg::CH_ETX && data_byte != afd_pkg::CH_ETB) begin
                        verdict  = 1'b1;
                        v_status = afd_pkg::ST_BAD_END;
                        v_rec    = rec_reg;
                    end
                    else begin
                        fin_next   = (data_byte == afd_pkg::CH_ETX);
                        sum_next   = sum_reg + data_byte;
                        phase_next = PH_HEX1;
                    end
                end
                PH_HEX1:
                begin
                    if (hv[4]) begin
                        verdict  = 1'b1;
                        v_status = afd_pkg::ST_BAD_HEX;
                        v_rec    = rec_reg;
                    end
                    else begin
                        hi_next    = hv[3:0];
                        phase_next = PH_HEX2;
                    end
                end
                PH_HEX2:
                begin
                    if (hv[4]) begin
                        verdict  = 1'b1;
                        v_status = afd_pkg::ST_BAD_HEX;
                        v_rec    = rec_reg;
                        v_given  = {hi_reg, 4'd0};
                    end
                    else if ({hi_reg, hv[3:0]} != sum_reg) begin
                        verdict  = 1'b1;
                        v_status = afd_pkg::ST_MISMATCH;
                        v_rec    = rec_reg;
                        v_given  = {hi_reg, hv[3:0]};
                    end
                    else begin
                        phase_next = PH_CR;
                    end
                end
                PH_CR:
                begin
                    if (data_byte != afd_pkg::CH_CR) begin
                        verdict  = 1'b1;
                        v_status = afd_pkg::ST_BAD_CRLF;
                        v_rec    = rec_reg;
                        v_given  = sum_reg;
                    end
                    else begin
                        phase_next = PH_LF;
                    end
                end
                PH_LF:
                begin
                    verdict = 1'b1;
                    v_rec   = rec_reg;
                    v_given = sum_reg;
                    if (data_byte != afd_pkg::CH_LF) begin
                        v_status = afd_pkg::ST_BAD_CRLF;
                    end
                    else begin
                        v_status = afd_pkg::ST_OK;
                        exp_next = {1'b0, exp_reg[2:0] + 3'd1};
                    end
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase

            if (verdict) begin
                phase_next = PH_DONE;
            end

            // End of buffer: close out whatever frame is in progress.
            if (buffer_last) begin
                if (!verdict) begin
                    case (phase_next)
                        PH_HUNT, PH_RECNO:
                        begin
                            verdict  = 1'b1;
                            v_status = afd_pkg::ST_NO_START;
                        end
                        PH_TEXT, PH_END:
                        begin
                            verdict  = 1'b1;
                            v_status = afd_pkg::ST_BAD_END;
                            v_rec    = rec_next;
                        end
                        PH_HEX1:
                        begin
                            verdict  = 1'b1;
                            v_status = afd_pkg::ST_BAD_HEX;
                            v_rec    = rec_next;
                        end
                        PH_HEX2:
                        begin
                            verdict  = 1'b1;
                            v_status = afd_pkg::ST_BAD_HEX;
                            v_rec    = rec_next;
                            v_given  = {hi_next, 4'd0};
                        end
                        PH_CR, PH_LF:
                        begin
                            verdict  = 1'b1;
                            v_status = afd_pkg::ST_BAD_CRLF;
                            v_rec    = rec_next;
                            v_given  = sum_next;
                        end
                        default:
                        begin
                            verdict = 1'b0;
                        end
                    endcase
                end
                phase_next = PH_HUNT;
            end
        end
    end

    always_comb
    begin
        produce = verdict | text;
        res     = '0;
        if (verdict) begin
            res.is_verdict        = 1'b1;
            res.status            = v_status;
            res.record_number     = v_rec;
            res.block_final       = fin_next;
            res.computed_checksum = sum_next;
            res.given_checksum    = v_given;
        end
        else if (text) begin
            res.text_byte = data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_HUNT;
            exp_reg   <= 4'd8;
            sum_reg   <= 8'd0;
            hi_reg    <= 4'd0;
            rec_reg   <= 3'd0;
            fin_reg   <= 1'b0;
        end
        else if (step) begin
            phase_reg <= phase_next;
            exp_reg   <= exp_next;
            sum_reg   <= sum_next;
            hi_reg    <= hi_next;
            rec_reg   <= rec_next;
            fin_reg   <= fin_next;
        end
    end

endmodule

// ----- hw/rtl/afd_out_reg.sv -----
// Result register towards the output channel.
module afd_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  afd_pkg::result_t res,
    input  logic             out_ready,
    output logic             space,
    output logic             out_valid,
    output afd_pkg::result_t res_out
);

    logic             vld_reg;
    afd_pkg::result_t res_reg;

    assign space     = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign res_out   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= 1'b0;
        end
        else if (load) begin
            vld_reg <= 1'b1;
        end
        else if (out_ready) begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            res_reg <= res;
        end
    end

endmodule

// ----- hw/rtl/astm_frame_deframer_top.sv -----
// Top level of the framed-record receiver: input register, parser, result register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------------
//  in      | input     | in_valid / in_ready  | mode, data_byte, buffer_last
//  out     | output    | out_valid / out_ready| is_verdict, text_byte, status, record_number,
//          |           |                      | block_final, computed_checksum, given_checksum
//
// One item per clock sustained while the result register has room. Path: the input register,
// then the single-pass parser logic into the result register; the parser state is registered.
// Reset (rst_n, async, active low) clears valids and parser state: hunting, record unknown.
// An item that yields no result passes on even while the result register is stalled;
// an item that yields a result waits in the input register until the result register frees.
module astm_frame_deframer_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       mode,
    input  logic [7:0] data_byte,
    input  logic       buffer_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       is_verdict,
    output logic [7:0] text_byte,
    output logic [3:0] status,
    output logic [2:0] record_number,
    output logic       block_final,
    output logic [7:0] computed_checksum,
    output logic [7:0] given_checksum
);

    // Input register
    logic       in_vld_reg;
    logic       mode_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    logic             produce;
    logic             space;
    logic             consume;
    afd_pkg::result_t res;
    afd_pkg::result_t res_out;

    // The held item retires when it makes no result or the result register has room.
    assign consume  = in_vld_reg && (!produce || space);
    assign in_ready = !in_vld_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready) begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            mode_reg <= mode;
            byte_reg <= data_byte;
            last_reg <= buffer_last;
        end
    end

    afd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (consume),
        .mode        (mode_reg),
        .data_byte   (byte_reg),
        .buffer_last (last_reg),
        .produce     (produce),
        .res         (res)
    );

    afd_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (consume && produce),
        .res       (res),
        .out_ready (out_ready),
        .space     (space),
        .out_valid (out_valid),
        .res_out   (res_out)
    );

    assign is_verdict        = res_out.is_verdict;
    assign text_byte         = res_out.text_byte;
    assign status            = res_out.status;
    assign record_number     = res_out.record_number;
    assign block_final       = res_out.block_final;
    assign computed_checksum = res_out.computed_checksum;
    assign given_checksum    = res_out.given_checksum;

    // Text items carry nothing but the byte.
    a_text_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_verdict) |->
            (status == afd_pkg::ST_OK && record_number == 3'd0 && block_final == 1'b0
             && computed_checksum == 8'd0 && given_checksum == 8'd0))
        else $error("text item carries verdict fields");

    // Verdicts carry no text byte and a defined status.
    a_verdict_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_verdict) |-> (text_byte == 8'd0 && status <= afd_pkg::ST_BAD_CRLF))
        else $error("malformed verdict");

    // An accepted item is held in the input register next cycle.
    a_in_capture: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> in_vld_reg)
        else $error("accepted item lost");

    // A waiting result is never overwritten.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(res_out) && out_valid))
        else $error("stalled result changed");

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for astm_frame_deframer_top: framed byte buffers in, text and verdicts out.
module testbench;

    // Parser phases of the prediction, in the order a frame walks through them.
    typedef enum logic [3:0] {
        P_HUNT,
        P_RECNO,
        P_TEXT,
        P_END,
        P_HEX1,
        P_HEX2,
        P_CR,
        P_LF,
        P_DONE
    } phase_t;

    // One received byte (or a session start) as offered to the block.
    typedef struct {
        logic       mode;
        logic [7:0] data;
        logic       last;
    } rx_item_t;

    localparam logic [3:0] REC_UNKNOWN = 4'd8;
    localparam int         STALL_LIMIT = 2000;   // cycles with no handshake on either side
    localparam int         DRAIN_CYCLES = 8;     // margin past the output path, for stray results
    localparam int         RANDOM_ITEMS = 1850;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       mode = 1'b0;
    logic [7:0] data_byte = 8'h00;
    logic       buffer_last = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       is_verdict;
    logic [7:0] text_byte;
    logic [3:0] status;
    logic [2:0] record_number;
    logic       block_final;
    logic [7:0] computed_checksum;
    logic [7:0] given_checksum;

    rx_item_t           rx_items_q[$];       // bytes still to be offered
    afd_pkg::result_t   frame_results_q[$];  // predicted results, oldest first
    int         error_count = 0;
    int         items_sent = 0;
    int         results_seen = 0;
    int         idle_cycles = 0;
    int         gen_next_rec = -1;   // stimulus side guess of the expected record; -1 unknown

    // Predicted parser state
    phase_t     prs_phase;
    logic [3:0] prs_expect;
    logic [7:0] prs_sum;
    logic [3:0] prs_hi;
    logic [2:0] prs_rec;
    logic       prs_final;

    astm_frame_deframer_top u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .mode              (mode),
        .data_byte         (data_byte),
        .buffer_last       (buffer_last),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .is_verdict        (is_verdict),
        .text_byte         (text_byte),
        .status            (status),
        .record_number     (record_number),
        .block_final       (block_final),
        .computed_checksum (computed_checksum),
        .given_checksum    (given_checksum)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Reporting
    // ------------------------------------------------------------------
    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] seen);
        if (seen !== want)
            flag_error($sformatf("result %0d %s: expected %0h, got %0h",
                                 results_seen, name, want, seen));
    endtask

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    task automatic clear_parser();
        prs_phase  = P_HUNT;
        prs_expect = REC_UNKNOWN;
        prs_sum    = 8'h00;
        prs_hi     = 4'h0;
        prs_rec    = 3'd0;
        prs_final  = 1'b0;
    endtask

    // Value of a hex digit in either case; 16 when the byte is not one.
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c >= afd_pkg::CH_ZERO && c <= afd_pkg::CH_NINE)
            return 5'(c - afd_pkg::CH_ZERO);
        if (c >= afd_pkg::CH_UA && c <= afd_pkg::CH_UF)
            return 5'(c - afd_pkg::CH_UA + afd_pkg::HEX_TEN);
        if (c >= afd_pkg::CH_LA && c <= afd_pkg::CH_LF_HEX)
            return 5'(c - afd_pkg::CH_LA + afd_pkg::HEX_TEN);
        return 5'd16;
    endfunction

    // A verdict closes the frame: the rest of the buffer is skipped.
    function automatic afd_pkg::result_t make_verdict(input afd_pkg::status_t st,
                                                      input logic [2:0] rec,
                                                      input logic [7:0] given);
        afd_pkg::result_t r;
        r = '0;
        r.is_verdict        = 1'b1;
        r.status            = st;
        r.record_number     = rec;
        r.block_final       = prs_final;
        r.computed_checksum = prs_sum;
        r.given_checksum    = given;
        prs_phase = P_DONE;
        return r;
    endfunction

    task automatic predict_frame_item(input logic m, input logic [7:0] b, input logic last);
        afd_pkg::result_t res;
        logic       have;
        logic [7:0] digit;
        logic [7:0] hi;
        logic [4:0] nib;
        logic [2:0] behind;
        res  = '0;
        have = 1'b0;
        hi   = {prs_hi, 4'h0};
        if (m)
        begin
            clear_parser();
            return;
        end
        case (prs_phase)
            P_HUNT:
            begin
                if (b == afd_pkg::CH_STX)
                begin
                    prs_phase = P_RECNO;
                    prs_sum   = 8'h00;
                    prs_hi    = 4'h0;
                    prs_rec   = 3'd0;
                    prs_final = 1'b0;
                end
            end
            P_RECNO:
            begin
                digit   = b - afd_pkg::CH_ZERO;
                prs_sum = b;
                if (digit > afd_pkg::MAX_RECORD)
                begin
                    res  = make_verdict(afd_pkg::ST_BAD_DIGIT, 3'd0, 8'h00);
                    have = 1'b1;
                end
                else
                begin
                    prs_rec = digit[2:0];
                    behind  = digit[2:0] + 3'd1;
                    if (prs_expect > 4'(afd_pkg::MAX_RECORD))
                    begin
                        // unknown record: adopt whatever arrives
                        prs_expect = {1'b0, digit[2:0]};
                        prs_phase  = P_TEXT;
                    end
                    else if ({1'b0, digit[2:0]} != prs_expect)
                    begin
                        if (behind == prs_expect[2:0])
                            res = make_verdict(afd_pkg::ST_RETX, digit[2:0], 8'h00);
                        else
                            res = make_verdict(afd_pkg::ST_OUT_OF_SEQ, digit[2:0], 8'h00);
                        have = 1'b1;
                    end
                    else
                        prs_phase = P_TEXT;
                end
            end
            P_TEXT:
            begin
                prs_sum = prs_sum + b;
                if (b == afd_pkg::CH_CR)
                    prs_phase = P_END;
                else if (!last)
                begin
                    res.text_byte = b;
                    have = 1'b1;
                end
            end
            P_END:
            begin
                if (b != afd_pkg::CH_ETX && b != afd_pkg::CH_ETB)
                begin
                    res  = make_verdict(afd_pkg::ST_BAD_END, prs_rec, 8'h00);
                    have = 1'b1;
                end
                else
                begin
                    prs_final = (b == afd_pkg::CH_ETX);
                    prs_sum   = prs_sum + b;
                    prs_phase = P_HEX1;
                end
            end
            P_HEX1:
            begin
                nib = nibble_of(b);
                if (nib[4])
                begin
                    res  = make_verdict(afd_pkg::ST_BAD_HEX, prs_rec, 8'h00);
                    have = 1'b1;
                end
                else
                begin
                    prs_hi    = nib[3:0];
                    prs_phase = P_HEX2;
                end
            end
            P_HEX2:
            begin
                nib = nibble_of(b);
                if (nib[4])
                begin
                    res  = make_verdict(afd_pkg::ST_BAD_HEX, prs_rec, hi);
                    have = 1'b1;
                end
                else if ((hi | {4'h0, nib[3:0]}) != prs_sum)
                begin
                    res  = make_verdict(afd_pkg::ST_MISMATCH, prs_rec, hi | {4'h0, nib[3:0]});
                    have = 1'b1;
                end
                else
                    prs_phase = P_CR;
            end
            P_CR:
            begin
                if (b != afd_pkg::CH_CR)
                begin
                    res  = make_verdict(afd_pkg::ST_BAD_CRLF, prs_rec, prs_sum);
                    have = 1'b1;
                end
                else
                    prs_phase = P_LF;
            end
            P_LF:
            begin
                if (b != afd_pkg::CH_LF)
                    res = make_verdict(afd_pkg::ST_BAD_CRLF, prs_rec, prs_sum);
                else
                begin
                    res = make_verdict(afd_pkg::ST_OK, prs_rec, prs_sum);
                    prs_expect = {1'b0, 3'(prs_expect[2:0] + 3'd1)};
                end
                have = 1'b1;
            end
            default:
                prs_phase = P_DONE;
        endcase

        // end of buffer: one verdict per buffer, whatever phase we stopped in
        if (last)
        begin
            if (!(have && res.is_verdict))
            begin
                have = 1'b1;
                case (prs_phase)
                    P_HUNT, P_RECNO:
                        res = make_verdict(afd_pkg::ST_NO_START, 3'd0, 8'h00);
                    P_TEXT, P_END:
                        res = make_verdict(afd_pkg::ST_BAD_END, prs_rec, 8'h00);
                    P_HEX1:
                        res = make_verdict(afd_pkg::ST_BAD_HEX, prs_rec, 8'h00);
                    P_HEX2:
                        res = make_verdict(afd_pkg::ST_BAD_HEX, prs_rec, {prs_hi, 4'h0});
                    P_CR, P_LF:
                        res = make_verdict(afd_pkg::ST_BAD_CRLF, prs_rec, prs_sum);
                    default:
                        have = 1'b0;
                endcase
            end
            prs_phase = P_HUNT;
        end
        if (have)
            frame_results_q = {frame_results_q, res};
    endtask

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    task automatic push_item(input logic m, input logic [7:0] b, input logic last);
        rx_item_t it;
        it.mode = m;
        it.data = b;
        it.last = last;
        rx_items_q = {rx_items_q, it};
    endtask

    task automatic queue_buffer(input logic [7:0] bytes[$]);
        foreach (bytes[i])
            push_item(1'b0, bytes[i], i == bytes.size() - 1);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
        if (nib < 4'd10)
            return afd_pkg::CH_ZERO + {4'h0, nib};
        return (upper ? afd_pkg::CH_UA : afd_pkg::CH_LA) + {4'h0, nib} - afd_pkg::HEX_TEN;
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] b;
        logic [4:0] nib;
        do
        begin
            b   = 8'($urandom);
            nib = nibble_of(b);
        end
        while (!nib[4]);
        return b;
    endfunction

    function automatic logic [7:0] other_byte(input logic [7:0] avoid_a,
                                              input logic [7:0] avoid_b);
        logic [7:0] b;
        do
            b = 8'($urandom);
        while (b == avoid_a || b == avoid_b);
        return b;
    endfunction

    // One random buffer: mostly a well-formed frame, sometimes flawed, cut short,
    // interrupted by a session start, or plain noise.
    task automatic add_random_buffer();
        logic [7:0] f[$];
        logic [7:0] b;
        logic [7:0] digit;
        logic [7:0] sum;
        logic [7:0] cks;
        logic [7:0] endc;
        logic       clean;
        int         pick;
        int         len;
        int         flaw;
        int         base;
        int         ins;
        pick = $urandom_range(0, 99);
        if (pick < 5)
        begin
            push_item(1'b1, 8'($urandom), 1'($urandom_range(0, 1)));
            gen_next_rec = -1;
            return;
        end
        if (pick < 15)
        begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
                push_item(1'b0, 8'($urandom), i == len - 1);
            return;
        end

        if ($urandom_range(0, 3) == 0)
        begin
            len = $urandom_range(1, 2);
            for (int i = 0; i < len; i++)
            begin
                b = 8'($urandom);
                f = {f, (b == afd_pkg::CH_STX) ? 8'h00 : b};
            end
        end
        base = f.size();

        pick = $urandom_range(0, 99);
        if (gen_next_rec >= 0 && pick < 80)
            digit = afd_pkg::CH_ZERO + 8'(gen_next_rec);
        else if (gen_next_rec >= 0 && pick < 87)
            digit = afd_pkg::CH_ZERO + 8'((gen_next_rec + 7) % 8);
        else if (pick < 95)
            digit = afd_pkg::CH_ZERO + 8'($urandom_range(0, 7));
        else
        begin
            digit = 8'($urandom);
            if (digit >= afd_pkg::CH_ZERO && digit <= afd_pkg::CH_ZERO + afd_pkg::MAX_RECORD)
                digit = 8'hFF;
        end
        clean = (digit >= afd_pkg::CH_ZERO && digit <= afd_pkg::CH_ZERO + afd_pkg::MAX_RECORD);
        if (clean && gen_next_rec < 0)
            gen_next_rec = digit - afd_pkg::CH_ZERO;
        clean = clean && (gen_next_rec == digit - afd_pkg::CH_ZERO);

        f = {f, afd_pkg::CH_STX};
        f = {f, digit};
        sum = digit;
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
        for (int i = 0; i < len; i++)
        begin
            b = 8'($urandom);
            if (b == afd_pkg::CH_CR)
                b = b ^ 8'h01;
            f = {f, b};
            sum = sum + b;
        end
        endc = $urandom_range(0, 1) ? afd_pkg::CH_ETX : afd_pkg::CH_ETB;
        f = {f, afd_pkg::CH_CR};
        f = {f, endc};
        sum = sum + afd_pkg::CH_CR + endc;

        flaw = ($urandom_range(0, 99) < 65) ? 0 : $urandom_range(1, 7);
        cks  = (flaw == 4) ? sum ^ (8'h01 << $urandom_range(0, 7)) : sum;
        f = {f, hex_char(cks[7:4], 1'($urandom_range(0, 1)))};
        f = {f, hex_char(cks[3:0], 1'($urandom_range(0, 1)))};
        f = {f, afd_pkg::CH_CR};
        f = {f, afd_pkg::CH_LF};

        // offsets after the text: end char, two hex digits, CR, LF
        case (flaw)
            1: f[base + len + 3] = other_byte(afd_pkg::CH_ETX, afd_pkg::CH_ETB);
            2: f[base + len + 4] = non_hex_byte();
            3: f[base + len + 5] = non_hex_byte();
            5: f[base + len + 6] = other_byte(afd_pkg::CH_CR, afd_pkg::CH_CR);
            6: f[base + len + 7] = other_byte(afd_pkg::CH_LF, afd_pkg::CH_LF);
            7: f = f[0:$urandom_range(base, f.size() - 2)];
            default: ;
        endcase
        if (flaw == 0 && clean)
            gen_next_rec = (gen_next_rec + 1) % 8;

        if ($urandom_range(0, 4) == 0)
        begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++)
                f = {f, 8'($urandom)};
        end

        ins = ($urandom_range(0, 99) < 3) ? $urandom_range(1, f.size() - 1) : -1;
        for (int i = 0; i < f.size(); i++)
        begin
            if (i == ins)
                push_item(1'b1, 8'($urandom), 1'($urandom_range(0, 1)));
            push_item(1'b0, f[i], i == f.size() - 1);
        end
        if (ins >= 0)
            gen_next_rec = -1;
    endtask

    // ------------------------------------------------------------------
    // Input driver: offers queued items; ~8% idle except for one calm stretch
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_frame_item(mode, data_byte, buffer_last);
                items_sent++;
            end
            // valid holds until taken, so a new item is only chosen when the slot is free
            if (!in_valid || in_ready)
            begin
                if (rx_items_q.size() != 0 &&
                    ((items_sent >= 600 && items_sent < 1000) || $urandom_range(0, 99) >= 8))
                begin
                    in_valid    <= 1'b1;
                    mode        <= rx_items_q[0].mode;
                    data_byte   <= rx_items_q[0].data;
                    buffer_last <= rx_items_q[0].last;
                    void'(rx_items_q.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: checks each accepted item against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        afd_pkg::result_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (frame_results_q.size() == 0)
                    flag_error($sformatf("result %0d arrived with nothing expected",
                                         results_seen));
                else
                begin
                    want = frame_results_q.pop_front();
                    compare_field("is_verdict", 8'(want.is_verdict), 8'(is_verdict));
                    compare_field("text_byte", want.text_byte, text_byte);
                    compare_field("status", 8'(want.status), 8'(status));
                    compare_field("record_number", 8'(want.record_number),
                                  8'(record_number));
                    compare_field("block_final", 8'(want.block_final), 8'(block_final));
                    compare_field("computed_checksum", want.computed_checksum,
                                  computed_checksum);
                    compare_field("given_checksum", want.given_checksum, given_checksum);
                end
                results_seen++;
            end
            out_ready <= (results_seen >= 400 && results_seen < 800) ||
                         ($urandom_range(0, 99) >= 8);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: no handshake on either side for too long while work is pending
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (rx_items_q.size() != 0 || in_valid || frame_results_q.size() != 0)
        begin
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: directed buffers, random buffers, reset, drain, verdict
    // ------------------------------------------------------------------
    initial
    begin
        clear_parser();

        // session start with every ignored field high
        push_item(1'b1, 8'hFF, 1'b1);
        // lone zero byte: buffer ends while hunting
        queue_buffer('{8'h00});
        // clean ETX frame, record 0 adopted from unknown; sum 0x81
        queue_buffer('{afd_pkg::CH_STX, afd_pkg::CH_ZERO, 8'h41, afd_pkg::CH_CR,
                       afd_pkg::CH_ETX, hex_char(4'h8, 1'b1), hex_char(4'h1, 1'b0),
                       afd_pkg::CH_CR, afd_pkg::CH_LF});
        // record 0 again while 1 is expected: retransmission
        queue_buffer('{afd_pkg::CH_STX, afd_pkg::CH_ZERO});
        // record digit out of range
        queue_buffer('{afd_pkg::CH_STX, 8'hFF});
        // record 5 while 1 is expected
        queue_buffer('{afd_pkg::CH_STX, afd_pkg::CH_ZERO + 8'd5});
        // buffer ends on a text byte: verdict only, no text item
        queue_buffer('{afd_pkg::CH_STX, afd_pkg::CH_ZERO + 8'd1, 8'h80});
        gen_next_rec = 1;

        while (rx_items_q.size() < RANDOM_ITEMS + 20)
            add_random_buffer();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (rx_items_q.size() != 0 || in_valid || frame_results_q.size() != 0)
            @(posedge clk);
        // catch any stray result after the last expected one
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
